>>> hw/rtl/mkte_pkg.sv
package mkte_pkg;

   localparam int KeyW      = 4;
   localparam int TimeW     = 32;
   localparam int EditW     = 2;
   localparam int CharW     = 7;
   localparam int LenW      = 8;
   localparam int WindowW   = 16;
   localparam int BufSizeW  = 9;
   localparam int TapW      = 4;
   localparam int CsrIndexW = 1;
   localparam int CsrDataW  = 16;

   localparam logic [KeyW-1:0] KEY_DIGIT_LIMIT = 4'd10;
   localparam logic [KeyW-1:0] KEY_BACKSPACE   = 4'd10;
   localparam logic [KeyW-1:0] KEY_IDLE        = 4'd11;

   localparam logic [EditW-1:0] EDIT_NONE    = 2'd0;
   localparam logic [EditW-1:0] EDIT_APPEND  = 2'd1;
   localparam logic [EditW-1:0] EDIT_REPLACE = 2'd2;
   localparam logic [EditW-1:0] EDIT_DELETE  = 2'd3;

   localparam logic [CsrIndexW-1:0] CSR_REPEAT_WINDOW = 1'd0;
   localparam logic [CsrIndexW-1:0] CSR_BUFFER_SIZE   = 1'd1;

   localparam logic [WindowW-1:0]  REPEAT_WINDOW_RESET = 16'd1000;
   localparam logic [BufSizeW-1:0] BUFFER_SIZE_RESET   = 9'd32;

   typedef struct packed {
      logic [TapW-1:0]  tap_index;
      logic [TimeW-1:0] last_press_time;
      logic [KeyW-1:0]  last_key;
      logic             after_delete;
      logic [LenW-1:0]  text_len;
   } state_type;

   // Number of characters on each digit key.
   function automatic logic [TapW-1:0] list_len(input logic [KeyW-1:0] key);
      logic [TapW-1:0] len;
      case (key)
         4'd0:    len = 4'd4;
         4'd1:    len = 4'd6;
         4'd7:    len = 4'd9;
         4'd9:    len = 4'd9;
         default: len = 4'd7;
      endcase
      return len;
   endfunction

   // Character at position idx of a digit key's list.
   function automatic logic [CharW-1:0] key_char(input logic [KeyW-1:0] key,
                                                 input logic [TapW-1:0] idx);
      logic [7:0] c;
      c = 8'd0;
      case (key)
         4'd0: begin
            case (idx)
               4'd0: c = ",";  4'd1: c = "*";  4'd2: c = "#";  default: c = "0";
            endcase
         end
         4'd1: begin
            case (idx)
               4'd0: c = "Q";  4'd1: c = "Z";  4'd2: c = "q";  4'd3: c = "z";
               4'd4: c = ".";  default: c = "1";
            endcase
         end
         4'd2: begin
            case (idx)
               4'd0: c = "A";  4'd1: c = "B";  4'd2: c = "C";  4'd3: c = "a";
               4'd4: c = "b";  4'd5: c = "c";  default: c = "2";
            endcase
         end
         4'd3: begin
            case (idx)
               4'd0: c = "D";  4'd1: c = "E";  4'd2: c = "F";  4'd3: c = "d";
               4'd4: c = "e";  4'd5: c = "f";  default: c = "3";
            endcase
         end
         4'd4: begin
            case (idx)
               4'd0: c = "G";  4'd1: c = "H";  4'd2: c = "I";  4'd3: c = "g";
               4'd4: c = "h";  4'd5: c = "i";  default: c = "4";
            endcase
         end
         4'd5: begin
            case (idx)
               4'd0: c = "J";  4'd1: c = "K";  4'd2: c = "L";  4'd3: c = "j";
               4'd4: c = "k";  4'd5: c = "l";  default: c = "5";
            endcase
         end
         4'd6: begin
            case (idx)
               4'd0: c = "M";  4'd1: c = "N";  4'd2: c = "O";  4'd3: c = "m";
               4'd4: c = "n";  4'd5: c = "o";  default: c = "6";
            endcase
         end
         4'd7: begin
            case (idx)
               4'd0: c = "P";  4'd1: c = "Q";  4'd2: c = "R";  4'd3: c = "S";
               4'd4: c = "p";  4'd5: c = "q";  4'd6: c = "r";  4'd7: c = "s";
               default: c = "7";
            endcase
         end
         4'd8: begin
            case (idx)
               4'd0: c = "T";  4'd1: c = "U";  4'd2: c = "V";  4'd3: c = "t";
               4'd4: c = "u";  4'd5: c = "v";  default: c = "8";
            endcase
         end
         4'd9: begin
            case (idx)
               4'd0: c = "W";  4'd1: c = "X";  4'd2: c = "Y";  4'd3: c = "Z";
               4'd4: c = "w";  4'd5: c = "x";  4'd6: c = "y";  4'd7: c = "z";
               default: c = "9";
            endcase
         end
         default: c = 8'd0;
      endcase
      return c[CharW-1:0];
   endfunction

endpackage

>>> hw/rtl/multitap_key_text_entry.sv
// Multi-tap keypad text entry engine.
// The req_ stream carries one key press per transfer: a key code (0-9 digit,
// 10 backspace, anything else no key) and the millisecond tick at the press.
// Every press yields exactly one rsp_ transfer: an edit command in rsp_tuser
// (none, append, replace last, delete last), the character for append or
// replace, and the text length after the edit.
// The csr_ port sets the repeat window in ms and the buffer size; write it
// only while no press is in flight.
// A press passes through the input register and then the response register
// on its way to the matching rsp_ transfer.
// Throughput is one press per cycle while rsp_tready is high; the state update
// of the edit logic is combinational, so consecutive presses never wait on each other.
// When rsp_tready is low the response register holds, the input register
// still fills, and req_tready drops once both are occupied.
// Synchronous reset empties both registers, clears the tracked text length
// and tap state, and restores the default window and buffer size.
module multitap_key_text_entry (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // key_code[3:0], now_ms[35:4], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // char_code[6:0], text_length[14:7], zero pad
   output logic [1:0]  rsp_tuser,   // edit[1:0]
   input  logic                               csr_we,
   input  logic [mkte_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [mkte_pkg::CsrDataW-1:0]      csr_wdata
);
   import mkte_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [KeyW-1:0]       in_key_ff, in_key_in;
   logic [TimeW-1:0]      in_time_ff, in_time_in;
   logic                  out_valid_ff, out_valid_in;
   logic [EditW-1:0]      out_edit_ff, out_edit_in;
   logic [CharW-1:0]      out_char_ff, out_char_in;
   logic [LenW-1:0]       out_len_ff, out_len_in;
   state_type             state_ff, state_in;
   logic [WindowW-1:0]    window_ff, window_in;
   logic [BufSizeW-1:0]   bufsize_ff, bufsize_in;

   state_type             step_nxt;
   logic [EditW-1:0]      step_edit;
   logic [CharW-1:0]      step_char;
   logic                  out_free;
   logic                  advance;

   mkte_step u_step (
      .cur              (state_ff),
      .key_code         (in_key_ff),
      .now_ms           (in_time_ff),
      .repeat_window_ms (window_ff),
      .buffer_size      (bufsize_ff),
      .nxt              (step_nxt),
      .edit             (step_edit),
      .char_code        (step_char)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_edit_ff;
   assign rsp_tdata  = {1'b0, out_len_ff, out_char_ff};

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_key_in    = in_key_ff;
      in_time_in   = in_time_ff;
      out_valid_in = out_valid_ff;
      out_edit_in  = out_edit_ff;
      out_char_in  = out_char_ff;
      out_len_in   = out_len_ff;
      state_in     = state_ff;
      window_in    = window_ff;
      bufsize_in   = bufsize_ff;

      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_key_in   = req_tdata[KeyW-1:0];
         in_time_in  = req_tdata[KeyW +: TimeW];
      end

      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_edit_in = step_edit;
         out_char_in = step_char;
         out_len_in  = step_nxt.text_len;
         state_in    = step_nxt;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_REPEAT_WINDOW: window_in  = csr_wdata[WindowW-1:0];
            CSR_BUFFER_SIZE:   bufsize_in = csr_wdata[BufSizeW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{tap_index: '0, last_press_time: '0, last_key: KEY_IDLE,
                           after_delete: 1'b0, text_len: '0};
         window_ff    <= REPEAT_WINDOW_RESET;
         bufsize_ff   <= BUFFER_SIZE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         window_ff    <= window_in;
         bufsize_ff   <= bufsize_in;
      end
      in_key_ff   <= in_key_in;
      in_time_ff  <= in_time_in;
      out_edit_ff <= out_edit_in;
      out_char_ff <= out_char_in;
      out_len_ff  <= out_len_in;
   end

endmodule

>>> hw/rtl/mkte_step.sv
module mkte_step (
   input  mkte_pkg::state_type                 cur,
   input  logic [mkte_pkg::KeyW-1:0]           key_code,
   input  logic [mkte_pkg::TimeW-1:0]          now_ms,
   input  logic [mkte_pkg::WindowW-1:0]        repeat_window_ms,
   input  logic [mkte_pkg::BufSizeW-1:0]       buffer_size,
   output mkte_pkg::state_type                 nxt,
   output logic [mkte_pkg::EditW-1:0]          edit,
   output logic [mkte_pkg::CharW-1:0]          char_code
);
   import mkte_pkg::*;

   logic [TimeW-1:0]    elapsed;
   logic [BufSizeW-1:0] max_wide;
   logic [LenW-1:0]     max_len;
   logic                fresh;
   logic [TapW:0]       tap_inc;
   logic [TapW-1:0]     tap_next;

   assign elapsed  = now_ms - cur.last_press_time;
   assign max_wide = (buffer_size == '0) ? '0 : buffer_size - BufSizeW'(1);
   assign max_len  = max_wide[BufSizeW-1] ? {LenW{1'b1}} : max_wide[LenW-1:0];
   assign fresh    = (elapsed > TimeW'(repeat_window_ms)) || (key_code != cur.last_key)
                     || cur.after_delete;
   assign tap_inc  = {1'b0, cur.tap_index} + (TapW+1)'(1);
   assign tap_next = (tap_inc >= {1'b0, list_len(key_code)}) ? '0 : tap_inc[TapW-1:0];

   always_comb begin
      nxt       = cur;
      edit      = EDIT_NONE;
      char_code = '0;
      if (key_code == KEY_BACKSPACE) begin
         if (cur.text_len != '0) begin
            nxt.text_len = cur.text_len - LenW'(1);
            edit         = EDIT_DELETE;
         end
         nxt.tap_index    = '0;
         nxt.after_delete = 1'b1;
      end else if (key_code < KEY_DIGIT_LIMIT) begin
         if (fresh) begin
            nxt.tap_index    = '0;
            nxt.after_delete = 1'b0;
            if (cur.text_len < max_len) begin
               char_code    = key_char(key_code, '0);
               nxt.text_len = cur.text_len + LenW'(1);
               edit         = EDIT_APPEND;
            end
         end else begin
            nxt.tap_index = tap_next;
            if (cur.text_len != '0) begin
               char_code = key_char(key_code, tap_next);
               edit      = EDIT_REPLACE;
            end
         end
         nxt.last_press_time = now_ms;
         nxt.last_key        = key_code;
      end
   end

endmodule
